// File: rtl/fclp_pkg.sv
`default_nettype none

package fclp_pkg;

  localparam int unsigned DataCntW = 11;
  localparam int unsigned SpacesW  = 8;

  localparam logic [DataCntW-1:0] MaxData = DataCntW'(1024);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChA     = 8'h61;

  localparam logic [SpacesW-1:0] SpacesWrite = SpacesW'(5);
  localparam logic [SpacesW-1:0] SpacesRead  = SpacesW'(4);
  localparam logic [SpacesW-1:0] SpacesOther = SpacesW'(3);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_PHYS  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                result_kind;
    logic [7:0]           data_byte;
    logic [15:0]          sector;
    logic [15:0]          byte_offset;
    logic [15:0]          length;
    logic [31:0]          flash_address;
    logic [DataCntW-1:0]  data_count;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/fclp_in_if.sv
`default_nettype none

interface fclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/fclp_out_if.sv
`default_nettype none

interface fclp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [15:0] sector;
  logic [15:0] byte_offset;
  logic [15:0] length;
  logic [31:0] flash_address;
  logic [10:0] data_count;

  modport source (
    output valid, output result_kind, output data_byte, output sector,
    output byte_offset, output length, output flash_address, output data_count,
    input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input sector,
    input byte_offset, input length, input flash_address, input data_count,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/fclp_in_stage.sv
`default_nettype none

module fclp_in_stage
  import fclp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fclp_in_if.sink    cmd_i,
  input  wire logic  free_i,
  output logic       adv_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign adv_o       = valid_q & free_i;
  assign cmd_i.ready = ~valid_q | free_i;
  assign byte_o      = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.ready) begin
      valid_d = cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold the beat until the decoder takes it
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      byte_q <= cmd_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fclp_decode.sv
`default_nettype none

module fclp_decode
  import fclp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output logic             emit_o,
  output result_t          res_o
);

  logic [SpacesW-1:0]  spaces_q, spaces_d;
  logic                seen_q, seen_d;
  logic [7:0]          opcode_q, opcode_d;
  logic [15:0]         sector_q, sector_d;
  logic [15:0]         offset_q, offset_d;
  logic [15:0]         length_q, length_d;
  logic [31:0]         addr_q, addr_d;
  logic [DataCntW-1:0] cnt_q, cnt_d;

  logic [15:0] fold16;
  logic [15:0] digit16;
  logic [31:0] fold32;
  logic [15:0] acc16;

  assign digit16 = {8'h00, byte_i} - {8'h00, ChZero};
  assign fold32  = (addr_q << 3) + (addr_q << 1) + {{16{digit16[15]}}, digit16};

  always_comb begin
    acc16 = 16'h0000;
    if (opcode_q == ChW) begin
      unique case (spaces_q)
        SpacesW'(4): acc16 = sector_q;
        SpacesW'(3): acc16 = offset_q;
        default:     acc16 = length_q;
      endcase
    end else if (opcode_q == ChR) begin
      unique case (spaces_q)
        SpacesW'(3): acc16 = sector_q;
        SpacesW'(2): acc16 = offset_q;
        default:     acc16 = length_q;
      endcase
    end else begin
      acc16 = length_q;
    end
  end

  assign fold16 = (acc16 << 3) + (acc16 << 1) + digit16;

  always_comb begin
    spaces_d = spaces_q;
    seen_d   = seen_q;
    opcode_d = opcode_q;
    sector_d = sector_q;
    offset_d = offset_q;
    length_d = length_q;
    addr_d   = addr_q;
    cnt_d    = cnt_q;
    emit_o   = 1'b0;
    res_o    = '0;

    priority if (byte_i == ChSpace) begin
      spaces_d = spaces_q - SpacesW'(1);
    end else if (!seen_q) begin
      opcode_d = byte_i;
      seen_d   = 1'b1;
      priority if (byte_i == ChW) begin
        spaces_d = SpacesWrite;
      end else if (byte_i == ChR) begin
        spaces_d = SpacesRead;
      end else begin
        spaces_d = SpacesOther;
      end
    end else if (opcode_q == ChW) begin
      priority if (spaces_q == SpacesW'(4)) begin
        sector_d = fold16;
      end else if (spaces_q == SpacesW'(3)) begin
        offset_d = fold16;
      end else if (spaces_q == SpacesW'(2)) begin
        length_d = fold16;
      end else if (spaces_q == SpacesW'(1)) begin
        if (cnt_q < MaxData) begin
          cnt_d = cnt_q + DataCntW'(1);
        end
        emit_o            = 1'b1;
        res_o.result_kind = KIND_DATA;
        res_o.data_byte   = byte_i;
        res_o.data_count  = cnt_d;
      end else begin
        spaces_d = spaces_q;
      end
    end else if (opcode_q == ChR) begin
      priority if (spaces_q == SpacesW'(3)) begin
        sector_d = fold16;
      end else if (spaces_q == SpacesW'(2)) begin
        offset_d = fold16;
      end else if (spaces_q == SpacesW'(1)) begin
        length_d = fold16;
      end else begin
        spaces_d = spaces_q;
      end
    end else if (opcode_q == ChA) begin
      priority if (spaces_q == SpacesW'(2)) begin
        addr_d = fold32;
      end else if (spaces_q == SpacesW'(1)) begin
        length_d = fold16;
      end else begin
        spaces_d = spaces_q;
      end
    end else begin
      spaces_d = spaces_q;
    end

    // count spent: issue a w, r or a command and drop the fields
    if (spaces_d == '0) begin
      priority if (opcode_d == ChW) begin
        emit_o              = 1'b1;
        res_o               = '0;
        res_o.result_kind   = KIND_WRITE;
        res_o.sector        = sector_d;
        res_o.byte_offset   = offset_d;
        res_o.length        = length_d;
        res_o.data_count    = cnt_d;
      end else if (opcode_d == ChR) begin
        emit_o              = 1'b1;
        res_o               = '0;
        res_o.result_kind   = KIND_READ;
        res_o.sector        = sector_d;
        res_o.byte_offset   = offset_d;
        res_o.length        = length_d;
      end else if (opcode_d == ChA) begin
        emit_o              = 1'b1;
        res_o               = '0;
        res_o.result_kind   = KIND_PHYS;
        res_o.length        = length_d;
        res_o.flash_address = addr_d;
      end else begin
        emit_o = 1'b0;
      end
      sector_d = '0;
      offset_d = '0;
      length_d = '0;
      addr_d   = '0;
      cnt_d    = '0;
      seen_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spaces_q <= '0;
      seen_q   <= 1'b0;
      opcode_q <= '0;
      sector_q <= '0;
      offset_q <= '0;
      length_q <= '0;
      addr_q   <= '0;
      cnt_q    <= '0;
    end else if (step_i) begin
      spaces_q <= spaces_d;
      seen_q   <= seen_d;
      opcode_q <= opcode_d;
      sector_q <= sector_d;
      offset_q <= offset_d;
      length_q <= length_d;
      addr_q   <= addr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fclp_out_stage.sv
`default_nettype none

module fclp_out_stage
  import fclp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire logic     emit_i,
  input  wire result_t  res_i,
  output logic          free_o,
  fclp_out_if.source    res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = ~valid_q | res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = emit_i;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.result_kind   = res_q.result_kind;
  assign res_o.data_byte     = res_q.data_byte;
  assign res_o.sector        = res_q.sector;
  assign res_o.byte_offset   = res_q.byte_offset;
  assign res_o.length        = res_q.length;
  assign res_o.flash_address = res_q.flash_address;
  assign res_o.data_count    = res_q.data_count;

endmodule

`default_nettype wire

// File: rtl/flash_command_line_parser_unit.sv
// Channel  Dir  Payload
// cmd_i    in   rx_byte (8)
// res_o    out  result_kind (2), data_byte (8), sector, byte_offset, length (16 each),
//               flash_address (32), data_count (11)
//
// One byte per cycle while the result register is free: a byte is held in the
// input register, is decoded into the parser state and lands in the result register.
// Reset clears the parser state and both valid flags; no clearing pass.
// A stalled result holds the decoder; the input register takes a byte while it
// is empty or the result register is free or being drained in the same cycle.
`default_nettype none

module flash_command_line_parser_unit
  import fclp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fclp_in_if.sink     cmd_i,
  fclp_out_if.source  res_o
);

  logic       free;
  logic       adv;
  logic [7:0] rx_byte;
  logic       emit;
  result_t    res;

  fclp_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .free_i (free),
    .adv_o  (adv),
    .byte_o (rx_byte)
  );

  fclp_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (rx_byte),
    .emit_o (emit),
    .res_o  (res)
  );

  fclp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv),
    .emit_i (emit),
    .res_i  (res),
    .free_o (free),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
